[src/mat_pkg.sv]
// Shared types and codes for the multi-slot alarm timer.
// Depends on nothing; used by mat_slot_table and multi_slot_alarm_timer.
package mat_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ALARM_CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 48;

  // input operations
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STOP  = 2'd1;
  localparam logic [1:0] KIND_ALARM = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_RUNNING  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_ID  = 1'd1;

  typedef struct packed {
    logic              active;
    logic [7:0]        owner;
    logic [31:0]       period;
    logic [31:0]       tag;
    logic              rep;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] origin;
  } slot_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    slot_t                 data;
  } slot_wr_t;

endpackage

[src/multi_slot_alarm_timer.sv]
// Top level of the multi-slot alarm timer: request sequencer, shared
// 48-bit adder and result register. Depends on mat_pkg and mat_slot_table.
//
// Usage:
//  - A request is taken at a rising edge with start high and busy low.
//    func selects tick, start timer or stop timer; other in_ fields are
//    the request's parameters. func 3 is taken and ignored.
//  - Results come out one per cycle at most, each shown for exactly one
//    cycle with out_valid high; out_last marks the final result of a
//    request. The receiver cannot stall, so nothing waits on it.
//  - Start and stop give one response each. A tick gives one alarm per
//    due slot (none if nothing is due), in slot order.
//  - Each request scans the table one slot per cycle, in these steps:
//      tick : counter advance, scan, then the last alarm is sent
//      start: scan, due-time sum and forced free, then arming and response
//      stop : scan, then the response
//    A new request is taken only once busy has fallen after the last step.
//  - The table read is registered, so the scan addresses it with the
//    next count and sees each slot in the cycle it is scanned.
//  - Each alarm is held back until the next is found, so that out_last can
//    be set on the final one; earlier ones appear while the scan goes on.
//  - Configuration (tick_period, invalid_id) must be written via cfg_we /
//    cfg_index / cfg_wdata by the user while idle; the block does not check.
//  - Reset (synchronous, rst_n low) empties every slot, zeroes the
//    millisecond counter and restores tick_period 100, invalid_id 255.
module multi_slot_alarm_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [7:0]                    in_client_id,
  input  logic [31:0]                   in_duration,
  input  logic [31:0]                   in_start_offset,
  input  logic [31:0]                   in_tag,
  input  logic                          in_repeat_req,
  input  logic                          in_forced,
  output logic                          out_valid,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_owner,
  output logic [2:0]                    out_status,
  output logic [31:0]                   out_elapsed,
  output logic [31:0]                   out_alarm_tag,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [mat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata
);

  localparam int TW = mat_pkg::TIME_W;
  localparam int IW = mat_pkg::SLOT_IDX_W;
  localparam int CW = mat_pkg::ALARM_CNT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_TICK_ADD = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_TICK_END = 3'd3;
  localparam logic [2:0] S_REQ_SUM  = 3'd4;
  localparam logic [2:0] S_REQ_FIN  = 3'd5;

  // configuration
  logic [15:0] tick_period_r;
  logic [7:0]  invalid_id_r;

  // control
  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] now_r, now_nxt;
  logic [TW-1:0] acc_r, acc_nxt;
  logic          own_found_r, own_found_nxt;
  logic [IW-1:0] own_idx_r, own_idx_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic [CW-1:0] alarm_cnt_r, alarm_cnt_nxt;

  // latched request
  logic [1:0]  func_r, func_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [31:0] dur_r, dur_nxt;
  logic [31:0] offs_r, offs_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic        rep_r, rep_nxt;
  logic        force_r, force_nxt;

  // alarm held back by one alarm to know which one is last
  logic        pend_valid_r, pend_valid_nxt;
  logic [7:0]  pend_owner_r, pend_owner_nxt;
  logic [31:0] pend_elapsed_r, pend_elapsed_nxt;
  logic [31:0] pend_tag_r, pend_tag_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_owner_r, out_owner_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [31:0] out_elapsed_r, out_elapsed_nxt;
  logic [31:0] out_tag_r, out_tag_nxt;
  logic        out_last_r, out_last_nxt;

  // shared datapath
  logic [TW-1:0]     add_a, add_b, add_sum;
  logic [31:0]       elapsed_w;
  logic              due_hit;
  logic              scan_done;
  logic              req_bad;
  logic              use_own;
  mat_pkg::slot_t    rd;
  mat_pkg::slot_wr_t wr;

  // registered read: address with the count of the coming cycle
  mat_slot_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (cnt_nxt),
    .rd_data (rd),
    .wr      (wr)
  );

  assign busy = (state_r != S_IDLE);

  // one 48-bit adder serves counter advance, due-time sums and rearming
  always_comb begin
    case (state_r)
      S_TICK_ADD: begin
        add_a = now_r;
        add_b = TW'(tick_period_r);
      end
      S_REQ_SUM: begin
        add_a = now_r;
        add_b = TW'(offs_r);
      end
      S_REQ_FIN: begin
        add_a = acc_r;
        add_b = TW'(dur_r);
      end
      default: begin
        add_a = rd.due;
        add_b = TW'(rd.period);
      end
    endcase
  end
  assign add_sum = add_a + add_b;

  assign elapsed_w = now_r[31:0] - rd.origin[31:0];
  assign due_hit   = rd.active && (now_r >= rd.due) &&
                     (alarm_cnt_r < CW'(mat_pkg::MAX_RESULTS));
  assign scan_done = (cnt_r == IW'(mat_pkg::NUM_SLOTS - 1));
  assign req_bad   = (id_r == invalid_id_r) || (dur_r == 32'd0);
  // a forced restart may reuse the slot it frees if that one is lowest
  assign use_own   = own_found_r && (!free_found_r || (own_idx_r < free_idx_r));

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    now_nxt          = now_r;
    acc_nxt          = acc_r;
    own_found_nxt    = own_found_r;
    own_idx_nxt      = own_idx_r;
    free_found_nxt   = free_found_r;
    free_idx_nxt     = free_idx_r;
    alarm_cnt_nxt    = alarm_cnt_r;
    func_nxt         = func_r;
    id_nxt           = id_r;
    dur_nxt          = dur_r;
    offs_nxt         = offs_r;
    tag_nxt          = tag_r;
    rep_nxt          = rep_r;
    force_nxt        = force_r;
    pend_valid_nxt   = pend_valid_r;
    pend_owner_nxt   = pend_owner_r;
    pend_elapsed_nxt = pend_elapsed_r;
    pend_tag_nxt     = pend_tag_r;
    out_valid_nxt    = 1'b0;
    out_kind_nxt     = out_kind_r;
    out_owner_nxt    = out_owner_r;
    out_status_nxt   = out_status_r;
    out_elapsed_nxt  = out_elapsed_r;
    out_tag_nxt      = out_tag_r;
    out_last_nxt     = out_last_r;
    wr               = '0;
    wr.idx           = cnt_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt       = in_func;
          id_nxt         = in_client_id;
          dur_nxt        = in_duration;
          offs_nxt       = in_start_offset;
          tag_nxt        = in_tag;
          rep_nxt        = in_repeat_req;
          force_nxt      = in_forced;
          cnt_nxt        = '0;
          own_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          alarm_cnt_nxt  = '0;
          pend_valid_nxt = 1'b0;
          case (in_func)
            mat_pkg::FUNC_TICK:  state_nxt = S_TICK_ADD;
            mat_pkg::FUNC_START: state_nxt = S_SCAN;
            mat_pkg::FUNC_STOP:  state_nxt = S_SCAN;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end

      S_TICK_ADD: begin
        now_nxt   = add_sum;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        if (func_r == mat_pkg::FUNC_TICK) begin
          if (due_hit) begin
            wr.en   = 1'b1;
            wr.data = rd;
            if (rd.rep) begin
              wr.data.due = add_sum;
            end else begin
              wr.data.active = 1'b0;
            end
            if (pend_valid_r) begin
              out_valid_nxt   = 1'b1;
              out_kind_nxt    = mat_pkg::KIND_ALARM;
              out_owner_nxt   = pend_owner_r;
              out_status_nxt  = mat_pkg::ST_OK;
              out_elapsed_nxt = pend_elapsed_r;
              out_tag_nxt     = pend_tag_r;
              out_last_nxt    = 1'b0;
            end
            pend_valid_nxt   = 1'b1;
            pend_owner_nxt   = rd.owner;
            pend_elapsed_nxt = elapsed_w;
            pend_tag_nxt     = rd.tag;
            alarm_cnt_nxt    = alarm_cnt_r + CW'(1);
          end
        end else begin
          if (rd.active && (rd.owner == id_r) && !own_found_r) begin
            own_found_nxt = 1'b1;
            own_idx_nxt   = cnt_r;
          end
          if (!rd.active && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cnt_r;
          end
        end
        if (scan_done) begin
          if (func_r == mat_pkg::FUNC_TICK) begin
            state_nxt = S_TICK_END;
          end else if (func_r == mat_pkg::FUNC_START) begin
            state_nxt = S_REQ_SUM;
          end else begin
            state_nxt = S_REQ_FIN;
          end
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end

      S_TICK_END: begin
        if (pend_valid_r) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = mat_pkg::KIND_ALARM;
          out_owner_nxt   = pend_owner_r;
          out_status_nxt  = mat_pkg::ST_OK;
          out_elapsed_nxt = pend_elapsed_r;
          out_tag_nxt     = pend_tag_r;
          out_last_nxt    = 1'b1;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end

      S_REQ_SUM: begin
        // forced restart: free the client's old slot before arming
        acc_nxt = add_sum;
        if (!req_bad && own_found_r && force_r) begin
          wr.en          = 1'b1;
          wr.idx         = own_idx_r;
          wr.data        = '0;
        end
        state_nxt = S_REQ_FIN;
      end

      S_REQ_FIN: begin
        out_valid_nxt   = 1'b1;
        out_owner_nxt   = id_r;
        out_elapsed_nxt = 32'd0;
        out_tag_nxt     = 32'd0;
        out_last_nxt    = 1'b1;
        if (func_r == mat_pkg::FUNC_START) begin
          out_kind_nxt = mat_pkg::KIND_START;
          if (req_bad) begin
            out_status_nxt = mat_pkg::ST_INVALID;
          end else if (own_found_r && !force_r) begin
            out_status_nxt = mat_pkg::ST_RUNNING;
          end else if (!use_own && !free_found_r) begin
            out_status_nxt = mat_pkg::ST_FULL;
          end else begin
            out_status_nxt     = mat_pkg::ST_OK;
            wr.en              = 1'b1;
            wr.idx             = use_own ? own_idx_r : free_idx_r;
            wr.data.active     = 1'b1;
            wr.data.owner      = id_r;
            wr.data.period     = dur_r;
            wr.data.tag        = tag_r;
            wr.data.rep        = rep_r;
            wr.data.due        = add_sum;
            wr.data.origin     = now_r;
          end
        end else begin
          out_kind_nxt = mat_pkg::KIND_STOP;
          if (own_found_r) begin
            out_status_nxt = mat_pkg::ST_OK;
            wr.en          = 1'b1;
            wr.idx         = own_idx_r;
            wr.data        = '0;
          end else begin
            out_status_nxt = mat_pkg::ST_NOTFOUND;
          end
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      now_r         <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      tick_period_r <= 16'd100;
      invalid_id_r  <= 8'd255;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mat_pkg::CFG_TICK_PERIOD: tick_period_r <= cfg_wdata;
          mat_pkg::CFG_INVALID_ID:  invalid_id_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r          <= cnt_nxt;
    acc_r          <= acc_nxt;
    own_found_r    <= own_found_nxt;
    own_idx_r      <= own_idx_nxt;
    free_found_r   <= free_found_nxt;
    free_idx_r     <= free_idx_nxt;
    alarm_cnt_r    <= alarm_cnt_nxt;
    func_r         <= func_nxt;
    id_r           <= id_nxt;
    dur_r          <= dur_nxt;
    offs_r         <= offs_nxt;
    tag_r          <= tag_nxt;
    rep_r          <= rep_nxt;
    force_r        <= force_nxt;
    pend_owner_r   <= pend_owner_nxt;
    pend_elapsed_r <= pend_elapsed_nxt;
    pend_tag_r     <= pend_tag_nxt;
    out_kind_r     <= out_kind_nxt;
    out_owner_r    <= out_owner_nxt;
    out_status_r   <= out_status_nxt;
    out_elapsed_r  <= out_elapsed_nxt;
    out_tag_r      <= out_tag_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_owner     = out_owner_r;
  assign out_status    = out_status_r;
  assign out_elapsed   = out_elapsed_r;
  assign out_alarm_tag = out_tag_r;
  assign out_last      = out_last_r;

  // a taken tick, start or stop request keeps the sequencer busy
  a_req_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == mat_pkg::FUNC_TICK ||
     in_func == mat_pkg::FUNC_START || in_func == mat_pkg::FUNC_STOP)) |=> busy)
    else $error("request taken but sequencer stayed idle");

  // start and stop responses are always the only result of their request
  a_resp_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != mat_pkg::KIND_ALARM) |-> out_last)
    else $error("response without last flag");

  // alarms always carry an ok status
  a_alarm_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == mat_pkg::KIND_ALARM) |-> out_status == mat_pkg::ST_OK)
    else $error("alarm with nonzero status");

  // after a request's last result, the next result needs a new request
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result right after a last result");

endmodule

[src/mat_slot_table.sv]
// Slot table of the alarm timer: one registered read port, one write port.
// Depends on mat_pkg. Only the active bits are reset.
module mat_slot_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [mat_pkg::SLOT_IDX_W-1:0] rd_idx,
  output mat_pkg::slot_t                 rd_data,
  input  mat_pkg::slot_wr_t              wr
);

  logic [mat_pkg::NUM_SLOTS-1:0] active_r;
  mat_pkg::slot_t                entry_r [mat_pkg::NUM_SLOTS];
  mat_pkg::slot_t                rd_entry_r;
  logic                          rd_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (wr.en) begin
      active_r[wr.idx] <= wr.data.active;
    end
  end

  // payload needs no reset: an inactive entry is never looked at
  always_ff @(posedge clk) begin
    if (wr.en) begin
      entry_r[wr.idx] <= wr.data;
    end
  end

  // read data shows up in the cycle after the address
  always_ff @(posedge clk) begin
    rd_entry_r  <= entry_r[rd_idx];
    rd_active_r <= active_r[rd_idx];
  end

  always_comb begin
    rd_data        = rd_entry_r;
    rd_data.active = rd_active_r;
  end

endmodule
